@@ rtl/gcca_pkg.sv @@
// ----------------------------------------------------------------------------
// gcca_pkg
// Shared widths, constants and arithmetic helpers for the great-circle
// central angle pipeline.
// ----------------------------------------------------------------------------
package gcca_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int TRIG_BITS    = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int LANES        = 3;

    localparam int DEG_W   = 24;
    localparam int ANGLE_W = 18;
    localparam int RED_W   = DEG_W + 2;
    localparam int MAG_W   = 23;
    localparam int CS_W    = 32;
    localparam int ROT_W   = 34;
    localparam int SQRT_W  = 62;
    localparam int ROOT_W  = 31;
    localparam int PROD_W  = 64;

    localparam logic signed [RED_W-1:0] DEG_FULL    = RED_W'(360 << FRAC_BITS);
    localparam logic signed [RED_W-1:0] DEG_HALF    = RED_W'(180 << FRAC_BITS);
    localparam logic signed [RED_W-1:0] DEG_QUARTER = RED_W'(90 << FRAC_BITS);

    // pi/180 in Q36, split so each partial product stays narrow
    localparam longint D2R_Q36   = 64'd1199381129;
    localparam int     D2R_SPLIT = 16;
    localparam int     D2R_HI_W  = 15;
    localparam logic [D2R_HI_W-1:0]  D2R_HI = D2R_HI_W'(D2R_Q36 >> D2R_SPLIT);
    localparam logic [D2R_SPLIT-1:0] D2R_LO = D2R_SPLIT'(D2R_Q36);
    localparam int PH_W       = MAG_W + D2R_HI_W;
    localparam int PL_W       = MAG_W + D2R_SPLIT;
    localparam int D2R_SUM_W  = PH_W + D2R_SPLIT + 2;
    localparam int D2R_SHIFT  = FRAC_BITS + 6;

    localparam int ROUND_SHIFT = TRIG_BITS - FRAC_BITS;

    typedef logic signed [CS_W-1:0]  trig_t;
    typedef logic signed [ROT_W-1:0] rot_t;
    typedef logic [SQRT_W-1:0]       sqr_t;
    typedef logic [ROOT_W-1:0]       root_t;

    localparam rot_t  INV_GAIN = ROT_W'(652032874);
    localparam rot_t  HALF_PI  = ROT_W'(1686629713);
    localparam trig_t Q30_ONE  = trig_t'(64'sd1 <<< TRIG_BITS);
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;

    localparam longint ATAN_HEAD [0:9] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149
    };

    function automatic rot_t atan_q30(input int i);
        rot_t r;
        if (i < 10)
            r = ROT_W'(ATAN_HEAD[i]);
        else
            r = ROT_W'(64'sd1 <<< (TRIG_BITS - i));
        return r;
    endfunction

    // Q30 x Q30 with round half up
    function automatic trig_t mul_q30(input trig_t a, input trig_t b);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b) + (64'sd1 <<< (TRIG_BITS - 1));
        return trig_t'(p >>> TRIG_BITS);
    endfunction

endpackage

@@ rtl/great_circle_central_angle.sv @@
// ----------------------------------------------------------------------------
// great_circle_central_angle
// Central angle between two points on a unit sphere, by the spherical law of
// cosines, as a fully pipelined datapath.
// ----------------------------------------------------------------------------
// A transaction enters whenever start is high; busy is always low, so a new
// point pair can be issued on every clock. Each transaction yields exactly one
// central_angle, shown for one cycle with done high, in issue order. The
// receiver cannot hold results off, and none is needed: the pipeline never
// stalls. Its stages are: angle reduction and degree-to-radian scaling (3),
// the 30-step sine/cosine CORDIC plus its sign-fix stage (31), the three
// product/clamp stages (3), the square-root pipeline with its squaring stage
// (32), the 30-step arccosine CORDIC with its quarter-turn pre-rotation (31),
// and the output rounding (1).
// ----------------------------------------------------------------------------
module great_circle_central_angle (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [gcca_pkg::DEG_W-1:0] first_latitude,
    input  logic        [gcca_pkg::DEG_W-1:0] first_longitude,
    input  logic signed [gcca_pkg::DEG_W-1:0] second_latitude,
    input  logic        [gcca_pkg::DEG_W-1:0] second_longitude,
    output logic                              done,
    output logic [gcca_pkg::ANGLE_W-1:0]      central_angle
);
    import gcca_pkg::*;

    // Lane 0: first latitude, lane 1: second latitude, lane 2: longitude gap.
    logic             prep_valid;
    rot_t [LANES-1:0] prep_z;
    logic [LANES-1:0] prep_flip;

    logic              sc_valid;
    trig_t [LANES-1:0] sc_sin, sc_cos;

    // product stages
    trig_t ss_reg, cc_reg, cd_reg;
    trig_t ss2_reg, ccd_reg;
    trig_t sum_reg;
    logic [2:0] prod_valid_reg;
    logic signed [CS_W:0] sum_wide;

    logic  sq_valid;
    trig_t sq_c;
    root_t sq_root;

    logic  ac_valid;
    rot_t  ac_angle;
    rot_t  ang_pos;
    logic [ROT_W-1:0] ang_round;

    logic [ANGLE_W-1:0] angle_reg;
    logic               done_reg;

    // The pipeline takes a transaction every cycle.
    assign busy = 1'b0;

    gcca_prep u_prep (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (start),
        .first_latitude   (first_latitude),
        .first_longitude  (first_longitude),
        .second_latitude  (second_latitude),
        .second_longitude (second_longitude),
        .out_valid        (prep_valid),
        .z_out            (prep_z),
        .flip_out         (prep_flip)
    );

    gcca_sincos u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .z_in      (prep_z),
        .flip_in   (prep_flip),
        .out_valid (sc_valid),
        .sin_out   (sc_sin),
        .cos_out   (sc_cos)
    );

    // Form sin a1 sin a2 + (cos a1 cos a2) cos d, one multiply deep per stage,
    // then clamp the sum to [-1, 1] so acos stays in its domain.
    assign sum_wide = (CS_W+1)'(ss2_reg) + (CS_W+1)'(ccd_reg);

    always_ff @(posedge clk)
    begin
        ss_reg  <= mul_q30(sc_sin[0], sc_sin[1]);
        cc_reg  <= mul_q30(sc_cos[0], sc_cos[1]);
        cd_reg  <= sc_cos[2];
        ss2_reg <= ss_reg;
        ccd_reg <= mul_q30(cc_reg, cd_reg);
        if (sum_wide > (CS_W+1)'(Q30_ONE))
            sum_reg <= Q30_ONE;
        else if (sum_wide < -(CS_W+1)'(Q30_ONE))
            sum_reg <= -Q30_ONE;
        else
            sum_reg <= CS_W'(sum_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= '0;
        else
            prod_valid_reg <= {prod_valid_reg[1:0], sc_valid};
    end

    gcca_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid_reg[2]),
        .c_in      (sum_reg),
        .out_valid (sq_valid),
        .c_out     (sq_c),
        .root_out  (sq_root)
    );

    gcca_acos u_acos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .c_in      (sq_c),
        .root_in   (sq_root),
        .out_valid (ac_valid),
        .angle_out (ac_angle)
    );

    // Drop negative angles to zero, round Q30 down to the output fraction,
    // and saturate to the port width.
    assign ang_pos   = ac_angle[ROT_W-1] ? '0 : ac_angle;
    assign ang_round = (ang_pos + (ROT_W'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;

    always_ff @(posedge clk)
    begin
        if (ang_round > ROT_W'(ANGLE_MAX))
            angle_reg <= ANGLE_MAX;
        else
            angle_reg <= ANGLE_W'(ang_round);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ac_valid;
    end

    assign done          = done_reg;
    assign central_angle = angle_reg;

endmodule

@@ rtl/gcca_prep.sv @@
// ----------------------------------------------------------------------------
// gcca_prep
// Angle reduction into [-90, 90] degrees and conversion to Q30 radians.
// ----------------------------------------------------------------------------
module gcca_prep (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic signed [gcca_pkg::DEG_W-1:0]     first_latitude,
    input  logic        [gcca_pkg::DEG_W-1:0]     first_longitude,
    input  logic signed [gcca_pkg::DEG_W-1:0]     second_latitude,
    input  logic        [gcca_pkg::DEG_W-1:0]     second_longitude,
    output logic                                  out_valid,
    output gcca_pkg::rot_t [gcca_pkg::LANES-1:0]  z_out,
    output logic [gcca_pkg::LANES-1:0]            flip_out
);
    import gcca_pkg::*;

    logic signed [RED_W-1:0] deg [LANES];
    logic [MAG_W-1:0]  mag_next [LANES];
    logic [LANES-1:0]  neg_next, flip_next;

    logic [MAG_W-1:0]  mag_reg [LANES];
    logic [LANES-1:0]  neg_reg, flip_reg;
    logic [PH_W-1:0]   phi_reg [LANES];
    logic [PL_W-1:0]   plo_reg [LANES];
    logic [LANES-1:0]  neg2_reg, flip2_reg;
    rot_t [LANES-1:0]  z_reg;
    logic [LANES-1:0]  flip3_reg;
    logic [2:0]        valid_reg;

    always_comb
    begin
        deg[0] = RED_W'(first_latitude);
        deg[1] = RED_W'(second_latitude);
        deg[2] = RED_W'($signed({1'b0, first_longitude}))
               - RED_W'($signed({1'b0, second_longitude}));
    end

    // fold into [-180, 180], then into [-90, 90] with a sign flip
    always_comb
    begin
        logic signed [RED_W-1:0] r;
        for (int l = 0; l < LANES; l++)
        begin
            r = deg[l];
            if (r > DEG_HALF)
                r = r - DEG_FULL;
            else if (r < -DEG_HALF)
                r = r + DEG_FULL;
            flip_next[l] = 1'b0;
            if (r > DEG_QUARTER)
            begin
                r = r - DEG_HALF;
                flip_next[l] = 1'b1;
            end
            else if (r < -DEG_QUARTER)
            begin
                r = r + DEG_HALF;
                flip_next[l] = 1'b1;
            end
            neg_next[l] = r[RED_W-1];
            mag_next[l] = r[RED_W-1] ? MAG_W'(-r) : MAG_W'(r);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        logic [D2R_SUM_W-1:0] s;
        for (int l = 0; l < LANES; l++)
        begin
            mag_reg[l] <= mag_next[l];
            phi_reg[l] <= PH_W'(mag_reg[l]) * PH_W'(D2R_HI);
            plo_reg[l] <= PL_W'(mag_reg[l]) * PL_W'(D2R_LO);
            s = (D2R_SUM_W'(phi_reg[l]) << D2R_SPLIT) + D2R_SUM_W'(plo_reg[l])
              + (D2R_SUM_W'(1) << (D2R_SHIFT - 1));
            z_reg[l] <= neg2_reg[l] ? -ROT_W'(s >> D2R_SHIFT) : ROT_W'(s >> D2R_SHIFT);
        end
        neg_reg   <= neg_next;
        flip_reg  <= flip_next;
        neg2_reg  <= neg_reg;
        flip2_reg <= flip_reg;
        flip3_reg <= flip2_reg;
    end

    assign out_valid = valid_reg[2];
    assign z_out     = z_reg;
    assign flip_out  = flip3_reg;

endmodule

@@ rtl/gcca_sincos.sv @@
// ----------------------------------------------------------------------------
// gcca_sincos
// Unrolled CORDIC rotation, one iteration per stage, three lanes side by side.
// ----------------------------------------------------------------------------
module gcca_sincos (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  gcca_pkg::rot_t [gcca_pkg::LANES-1:0]  z_in,
    input  logic [gcca_pkg::LANES-1:0]            flip_in,
    output logic                                  out_valid,
    output gcca_pkg::trig_t [gcca_pkg::LANES-1:0] sin_out,
    output gcca_pkg::trig_t [gcca_pkg::LANES-1:0] cos_out
);
    import gcca_pkg::*;

    rot_t [LANES-1:0]  x_reg [1:CORDIC_STEPS];
    rot_t [LANES-1:0]  y_reg [1:CORDIC_STEPS];
    rot_t [LANES-1:0]  z_reg [1:CORDIC_STEPS];
    logic [LANES-1:0]  f_reg [1:CORDIC_STEPS];
    logic [CORDIC_STEPS:0] valid_reg;
    trig_t [LANES-1:0] sin_reg, cos_reg;

    genvar k;
    for (k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        rot_t [LANES-1:0] xc, yc, zc;
        logic [LANES-1:0] fc;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    xc[l] = INV_GAIN;
                    yc[l] = '0;
                end
            end
            assign zc = z_in;
            assign fc = flip_in;
        end
        else
        begin : g_next
            assign xc = x_reg[k];
            assign yc = y_reg[k];
            assign zc = z_reg[k];
            assign fc = f_reg[k];
        end

        always_ff @(posedge clk)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (!zc[l][ROT_W-1])
                begin
                    x_reg[k+1][l] <= xc[l] - (yc[l] >>> k);
                    y_reg[k+1][l] <= yc[l] + (xc[l] >>> k);
                    z_reg[k+1][l] <= zc[l] - atan_q30(k);
                end
                else
                begin
                    x_reg[k+1][l] <= xc[l] + (yc[l] >>> k);
                    y_reg[k+1][l] <= yc[l] - (xc[l] >>> k);
                    z_reg[k+1][l] <= zc[l] + atan_q30(k);
                end
            end
            f_reg[k+1] <= fc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[CORDIC_STEPS-1:0], in_valid};
    end

    // negate both results for angles folded across the quarter turn
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            sin_reg[l] <= f_reg[CORDIC_STEPS][l] ? -CS_W'(y_reg[CORDIC_STEPS][l])
                                                 : CS_W'(y_reg[CORDIC_STEPS][l]);
            cos_reg[l] <= f_reg[CORDIC_STEPS][l] ? -CS_W'(x_reg[CORDIC_STEPS][l])
                                                 : CS_W'(x_reg[CORDIC_STEPS][l]);
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign sin_out   = sin_reg;
    assign cos_out   = cos_reg;

endmodule

@@ rtl/gcca_sqrt.sv @@
// ----------------------------------------------------------------------------
// gcca_sqrt
// Pipelined integer square root of 2^60 - c^2, one result bit per stage.
// ----------------------------------------------------------------------------
module gcca_sqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  gcca_pkg::trig_t   c_in,
    output logic              out_valid,
    output gcca_pkg::trig_t   c_out,
    output gcca_pkg::root_t   root_out
);
    import gcca_pkg::*;

    sqr_t  rem_reg [0:SQRT_STEPS];
    sqr_t  res_reg [0:SQRT_STEPS];
    trig_t c_reg   [0:SQRT_STEPS];
    logic [SQRT_STEPS:0] valid_reg;

    always_ff @(posedge clk)
    begin
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(c_in) * PROD_W'(c_in);
        rem_reg[0] <= (SQRT_W'(1) << (2 * TRIG_BITS)) - SQRT_W'(p);
        res_reg[0] <= '0;
        c_reg[0]   <= c_in;
    end

    genvar k;
    for (k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam sqr_t BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        sqr_t t;
        assign t = res_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            if (rem_reg[k] >= t)
            begin
                rem_reg[k+1] <= rem_reg[k] - t;
                res_reg[k+1] <= (res_reg[k] >> 1) + BIT;
            end
            else
            begin
                rem_reg[k+1] <= rem_reg[k];
                res_reg[k+1] <= res_reg[k] >> 1;
            end
            c_reg[k+1] <= c_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[SQRT_STEPS-1:0], in_valid};
    end

    assign out_valid = valid_reg[SQRT_STEPS];
    assign c_out     = c_reg[SQRT_STEPS];
    assign root_out  = ROOT_W'(res_reg[SQRT_STEPS]);

endmodule

@@ rtl/gcca_acos.sv @@
// ----------------------------------------------------------------------------
// gcca_acos
// Unrolled CORDIC vectoring on (c, sqrt(1 - c^2)) to recover the angle.
// ----------------------------------------------------------------------------
module gcca_acos (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  gcca_pkg::trig_t  c_in,
    input  gcca_pkg::root_t  root_in,
    output logic             out_valid,
    output gcca_pkg::rot_t   angle_out
);
    import gcca_pkg::*;

    rot_t x_reg [0:CORDIC_STEPS];
    rot_t y_reg [0:CORDIC_STEPS];
    rot_t z_reg [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0] valid_reg;

    // pre-rotate by a quarter turn when the cosine is negative
    always_ff @(posedge clk)
    begin
        if (c_in[CS_W-1])
        begin
            x_reg[0] <= ROT_W'({1'b0, root_in});
            y_reg[0] <= -ROT_W'(c_in);
            z_reg[0] <= HALF_PI;
        end
        else
        begin
            x_reg[0] <= ROT_W'(c_in);
            y_reg[0] <= ROT_W'({1'b0, root_in});
            z_reg[0] <= '0;
        end
    end

    genvar k;
    for (k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (y_reg[k] > 0)
            begin
                x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                z_reg[k+1] <= z_reg[k] + atan_q30(k);
            end
            else
            begin
                x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                z_reg[k+1] <= z_reg[k] - atan_q30(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[CORDIC_STEPS-1:0], in_valid};
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign angle_out = z_reg[CORDIC_STEPS];

endmodule

@@ test/great_circle_central_angle_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_central_angle_checker
// Watches accepted point pairs and emitted angles, predicts each angle with
// an independent fixed-point model and compares results in issue order.
// ----------------------------------------------------------------------------
module great_circle_central_angle_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic signed [gcca_pkg::DEG_W-1:0] first_latitude,
    input  logic        [gcca_pkg::DEG_W-1:0] first_longitude,
    input  logic signed [gcca_pkg::DEG_W-1:0] second_latitude,
    input  logic        [gcca_pkg::DEG_W-1:0] second_longitude,
    input  logic                              done,
    input  logic [gcca_pkg::ANGLE_W-1:0]      central_angle,
    output int                                failures,
    output int                                pending
);
    import gcca_pkg::*;

    localparam longint ONE_Q30 = 64'sd1 <<< TRIG_BITS;

    logic [ANGLE_W-1:0] angle_queue [$];

    function automatic longint floor_shift(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint arctan_step(input int i);
        if (i < 10)
            return ATAN_HEAD[i];
        return 64'sd1 <<< (TRIG_BITS - i);
    endfunction

    function automatic longint round_mul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // sine and cosine of a degree angle, reduced to [-90, 90] with a sign flip
    task automatic sin_cos(input longint deg, output longint sn, output longint cs);
        longint full, half, quarter, r, mag, z, x, y, xs, ys;
        bit flip;
        full = 64'sd360 <<< FRAC_BITS;
        half = 64'sd180 <<< FRAC_BITS;
        quarter = 64'sd90 <<< FRAC_BITS;
        flip = 0;
        r = deg % full;
        if (r > half)
            r -= full;
        else if (r < -half)
            r += full;
        if (r > quarter)
        begin
            r -= half;
            flip = 1;
        end
        else if (r < -quarter)
        begin
            r += half;
            flip = 1;
        end
        mag = (r < 0) ? -r : r;
        z = (mag * D2R_Q36 + (64'sd1 <<< (FRAC_BITS + 5))) >>> (FRAC_BITS + 6);
        if (r < 0)
            z = -z;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= arctan_step(i);
            end
            else
            begin
                x += ys; y -= xs; z += arctan_step(i);
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic longint arccos_q30(input longint c);
        longint x, y, z, t, xs, ys;
        y = int_sqrt(64'(ONE_Q30 * ONE_Q30) - 64'(c * c));
        x = c;
        z = 0;
        if (x < 0)
        begin
            t = x; x = y; y = -t; z = 1686629713;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0)
            begin
                x += ys; y -= xs; z += arctan_step(i);
            end
            else
            begin
                x -= ys; y += xs; z -= arctan_step(i);
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    task automatic predict_angle(input longint lat_a, input longint lon_a,
                                 input longint lat_b, input longint lon_b,
                                 output logic [ANGLE_W-1:0] angle);
        longint sa, ca, sb, cb, sd, cd, cos_sum, ang, res;
        sin_cos(lat_a, sa, ca);
        sin_cos(lat_b, sb, cb);
        sin_cos(lon_a - lon_b, sd, cd);
        cos_sum = round_mul(sa, sb) + round_mul(round_mul(ca, cb), cd);
        if (cos_sum > ONE_Q30)
            cos_sum = ONE_Q30;
        if (cos_sum < -ONE_Q30)
            cos_sum = -ONE_Q30;
        ang = arccos_q30(cos_sum);
        res = (ang + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (res > 262143)
            res = 262143;
        angle = ANGLE_W'(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [ANGLE_W-1:0] want;
        if (!rst_n)
        begin
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_angle(longint'(first_latitude), longint'({1'b0, first_longitude}),
                              longint'(second_latitude), longint'({1'b0, second_longitude}),
                              want);
                angle_queue.push_back(want);
            end
            if (done)
            begin
                if (angle_queue.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected central_angle %0d", central_angle);
                    failures <= failures + 1;
                end
                else
                begin
                    want = angle_queue.pop_front();
                    if (want !== central_angle)
                    begin
                        if (failures < 10)
                            $display("central_angle mismatch: expected %0d actual %0d",
                                     want, central_angle);
                        failures <= failures + 1;
                    end
                end
            end
            pending <= angle_queue.size();
        end
    end

endmodule

@@ test/great_circle_central_angle_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_central_angle_test
// Drives directed and random point pairs in bursts into the central angle
// pipeline; the checker predicts and compares every angle.
// ----------------------------------------------------------------------------
module great_circle_central_angle_test;
    import gcca_pkg::*;

    localparam int LAT_MAX   = 5898240;
    localparam int LON_MAX   = 11796480;
    localparam int LATENCY   = 101;
    localparam int RAND_ITEMS = 1600;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [DEG_W-1:0] first_latitude;
    logic        [DEG_W-1:0] first_longitude;
    logic signed [DEG_W-1:0] second_latitude;
    logic        [DEG_W-1:0] second_longitude;
    logic done;
    logic [ANGLE_W-1:0] central_angle;
    int failures;
    int pending;

    great_circle_central_angle uut (.*);

    great_circle_central_angle_checker checker_inst (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    int burst_left;

    // present one pair; hold start until it is taken, sometimes idle between bursts
    task automatic send_pair(input int la, input int oa, input int lb, input int ob);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        start <= 1'b1;
        first_latitude <= DEG_W'(la);
        first_longitude <= DEG_W'(oa);
        second_latitude <= DEG_W'(lb);
        second_longitude <= DEG_W'(ob);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        burst_left--;
    endtask

    function automatic int rand_lat(input int mode);
        // mostly in range, sometimes any 24-bit pattern (which may lie beyond +-90 degrees)
        if (mode == 0)
            return int'($urandom());
        return int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
    endfunction

    function automatic int rand_lon(input int mode);
        if (mode == 0)
            return int'($urandom());
        return int'($urandom_range(0, LON_MAX));
    endfunction

    initial
    begin
        int m, waited;
        rst_n = 0;
        start = 0;
        first_latitude = '0;
        first_longitude = '0;
        second_latitude = '0;
        second_longitude = '0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: identical points, poles, antipodes, date line, extremes
        send_pair(0, 0, 0, 0);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(LAT_MAX, 0, LAT_MAX, LON_MAX);
        send_pair(0, 0, 0, LON_MAX / 2);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(0, LON_MAX, 0, 0);
        send_pair(LAT_MAX / 2, 10, -LAT_MAX / 2, LON_MAX / 2 + 10);
        send_pair('h7fffff, 'hffffff, 'h800000, 'h000000);
        send_pair('h800000, 'h000000, 'h7fffff, 'hffffff);
        send_pair('hffffff, 'hffffff, 'hffffff, 'hffffff);
        send_pair(-LAT_MAX, LON_MAX, LAT_MAX, 0);
        send_pair(1, 0, 0, 1);
        send_pair(3 * 65536, 100, 3 * 65536, 101);
        send_pair(LAT_MAX + 65536, 0, -LAT_MAX - 65536, 0);
        send_pair(0, 200 * 65536, 0, 20 * 65536);
        send_pair(45 * 65536, 0, -45 * 65536, 90 * 65536);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            m = ($urandom_range(0, 7) == 0) ? 0 : 1;
            send_pair(rand_lat(m), rand_lon(m), rand_lat(m), rand_lon(m));
        end
        start <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 10 * LATENCY)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ great_circle_central_angle.f @@
rtl/gcca_pkg.sv
rtl/gcca_prep.sv
rtl/gcca_sincos.sv
rtl/gcca_sqrt.sv
rtl/gcca_acos.sv
rtl/great_circle_central_angle.sv
test/great_circle_central_angle_checker.sv
test/great_circle_central_angle_test.sv
